FILE: rtl/core/dtp_pkg.sv
// ----------------------------------------------------------------------------
// Date/time text parser package
// Shared widths, character codes, range limits and the character class record
// that travels from the front end through the queue to the parse engine.
// ----------------------------------------------------------------------------
package dtp_pkg;

  // Width of every numeric result field, two's complement.
  localparam int VALUE_BITS = 17;

  // Entries in the queue between the front end and the parse engine.
  localparam int QueueDepth = 2;

  // Character codes.
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChColon = 8'h3A;

  // Range limits and year window.
  localparam int DayMax      = 31;
  localparam int MonthMax    = 12;
  localparam int HourMax     = 23;
  localparam int MinSecMax   = 59;
  localparam int YearWindow  = 70;
  localparam int YearTwoDig  = 100;
  localparam int Century2000 = 2000;
  localparam int Century1900 = 1900;

  // Status codes of a result.
  typedef enum logic [3:0] {
    StOk          = 4'd0,
    StNoDaySlash  = 4'd1,
    StBadDay      = 4'd2,
    StNoMonSlash  = 4'd3,
    StBadMonth    = 4'd4,
    StNoHourColon = 4'd5,
    StBadHour     = 4'd6,
    StBadMinute   = 4'd7,
    StBadSecond   = 4'd8
  } dtp_status_e;

  // One classified character.
  typedef struct packed {
    logic [7:0] ch;
    logic       is_zero;
    logic       is_space;
    logic       is_ws;
    logic       is_sign;
    logic       is_minus;
    logic       is_digit;
    logic [3:0] digit;
  } dtp_char_t;

  // Write side of the queue.
  typedef struct packed {
    logic      valid;
    dtp_char_t data;
  } dtp_push_t;

endpackage

FILE: rtl/core/dtp_front.sv
// ----------------------------------------------------------------------------
// Date/time text parser front end
// Accepts text bytes and classifies each one into a character record.
// ----------------------------------------------------------------------------
module dtp_front
  import dtp_pkg::*;
(
  input  logic       in_valid_i,
  input  logic [7:0] ch_i,
  output logic       in_stall_o,
  input  logic       full_i,
  output dtp_push_t  push_o
);

  function automatic dtp_char_t classify(logic [7:0] c);
    dtp_char_t r;
    r.ch       = c;
    r.is_zero  = (c == ChNul);
    r.is_space = (c == ChSpace);
    r.is_ws    = (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
    r.is_sign  = (c == ChPlus) || (c == ChMinus);
    r.is_minus = (c == ChMinus);
    r.is_digit = (c >= ChZero) && (c <= ChNine);
    r.digit    = c[3:0];
    return r;
  endfunction

  // The queue is the only thing that can hold the input back.
  assign in_stall_o   = full_i;
  assign push_o.valid = in_valid_i && !full_i;
  assign push_o.data  = classify(ch_i);

endmodule

FILE: rtl/core/dtp_queue.sv
// ----------------------------------------------------------------------------
// Date/time text parser queue
// Short FIFO of classified characters between the front end and the engine.
// ----------------------------------------------------------------------------
module dtp_queue
  import dtp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dtp_push_t push_i,
  output logic      full_o,
  output logic      valid_o,
  output dtp_char_t data_o,
  input  logic      pop_i
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  dtp_char_t         mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] bump(logic [PtrW-1:0] p);
    if (p == PtrW'(QueueDepth - 1)) begin
      return '0;
    end
    return p + PtrW'(1);
  endfunction

  always_comb begin
    wr_d  = push_i.valid ? bump(wr_q) : wr_q;
    rd_d  = pop_i ? bump(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(push_i.valid) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_q] <= push_i.data;
    end
  end

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

endmodule

FILE: rtl/core/dtp_back.sv
// ----------------------------------------------------------------------------
// Date/time text parser engine
// Consumes one classified character per cycle, but holds a terminator while a
// result waits, runs the field scanner and loads the result at the terminator.
// ----------------------------------------------------------------------------
module dtp_back
  import dtp_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  dtp_char_t                    q_data_i,
  output logic                         q_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [VALUE_BITS-1:0] day_o,
  output logic signed [VALUE_BITS-1:0] month_o,
  output logic signed [VALUE_BITS-1:0] year_o,
  output logic signed [VALUE_BITS-1:0] hour_o,
  output logic signed [VALUE_BITS-1:0] minute_o,
  output logic signed [VALUE_BITS-1:0] second_o,
  output logic [3:0]                   status_o
);

  localparam int AccW  = VALUE_BITS - 1;
  localparam int WideW = AccW + 4;
  localparam int NumFields = 6;
  localparam int FieldW = $clog2(NumFields);

  localparam logic [AccW-1:0] AccMax = '1;

  typedef logic signed [VALUE_BITS-1:0] val_t;

  localparam val_t VDayMax  = val_t'(DayMax);
  localparam val_t VMonMax  = val_t'(MonthMax);
  localparam val_t VHourMax = val_t'(HourMax);
  localparam val_t VMsMax   = val_t'(MinSecMax);
  localparam val_t VYearWin = val_t'(YearWindow);
  localparam val_t VYear100 = val_t'(YearTwoDig);
  localparam val_t VC2000   = val_t'(Century2000);
  localparam val_t VC1900   = val_t'(Century1900);
  localparam val_t VOne     = val_t'(1);

  localparam logic [FieldW-1:0] FDay  = FieldW'(0);
  localparam logic [FieldW-1:0] FMon  = FieldW'(1);
  localparam logic [FieldW-1:0] FYear = FieldW'(2);
  localparam logic [FieldW-1:0] FHour = FieldW'(3);
  localparam logic [FieldW-1:0] FMin  = FieldW'(4);
  localparam logic [FieldW-1:0] FSec  = FieldW'(5);

  typedef enum logic [2:0] {
    PhLead, PhDay, PhMonth, PhYear, PhHskip, PhHour, PhMin, PhSec
  } phase_e;

  // Scanner state of the number being read.
  typedef struct packed {
    logic [AccW-1:0] acc;
    logic            neg;
    logic            dseen;
    logic [7:0]      first;
    logic            sign;
    logic            started;
    logic            sponly;
  } num_t;

  typedef struct packed {
    num_t num;
    logic last;
  } feed_t;

  typedef struct packed {
    logic        wr;
    val_t        val;
    logic        stop;
    dtp_status_e code;
    phase_e      next;
    logic        clear;
    logic        again;
  } close_t;

  localparam num_t NumClear = '{acc: '0, neg: 1'b0, dseen: 1'b0, first: '0,
                                sign: 1'b0, started: 1'b0, sponly: 1'b1};

  function automatic num_t add_digit(num_t n, logic [3:0] d);
    logic [WideW-1:0] wide;
    num_t r;
    r    = n;
    wide = ({4'b0000, n.acc} << 3) + ({4'b0000, n.acc} << 1) + WideW'(d);
    r.acc   = (wide > {4'b0000, AccMax}) ? AccMax : wide[AccW-1:0];
    r.dseen = 1'b1;
    return r;
  endfunction

  function automatic feed_t feed(num_t n, dtp_char_t c);
    feed_t r;
    r.num  = n;
    r.last = 1'b0;
    if (!n.started) begin
      r.num.started = 1'b1;
      r.num.first   = c.ch;
    end
    if (n.dseen || n.sign) begin
      if (c.is_digit) r.num = add_digit(r.num, c.digit);
      else r.last = 1'b1;
    end else if (c.is_ws) begin
      if (!c.is_space) r.num.sponly = 1'b0;
    end else if (c.is_sign) begin
      r.num.sign = 1'b1;
      r.num.neg  = c.is_minus;
    end else if (c.is_digit) begin
      r.num = add_digit(r.num, c.digit);
    end else begin
      r.last = 1'b1;
    end
    return r;
  endfunction

  function automatic val_t num_value(num_t n);
    val_t mag;
    mag = $signed({1'b0, n.acc});
    if (!n.dseen) return '0;
    return n.neg ? -mag : mag;
  endfunction

  // Ends the field of phase ph at character c.
  function automatic close_t close_field(phase_e ph, num_t n, dtp_char_t c);
    close_t     r;
    val_t       v;
    logic [7:0] nds;
    v       = num_value(n);
    nds     = n.dseen ? c.ch : n.first;
    r.wr    = 1'b1;
    r.val   = v;
    r.stop  = 1'b0;
    r.code  = StOk;
    r.next  = ph;
    r.clear = 1'b0;
    r.again = 1'b0;
    unique case (ph)
      PhDay: begin
        if (nds != ChSlash) begin
          r.stop = 1'b1; r.code = StNoDaySlash;
        end else if ((v > VDayMax) || (v == '0)) begin
          r.stop = 1'b1; r.code = StBadDay;
        end else begin
          r.next = PhMonth; r.clear = 1'b1;
        end
      end
      PhMonth: begin
        if (nds != ChSlash) begin
          r.stop = 1'b1; r.code = StNoMonSlash;
        end else if ((v > VMonMax) || (v == '0)) begin
          r.stop = 1'b1; r.code = StBadMonth;
        end else begin
          r.val = v - VOne; r.next = PhYear; r.clear = 1'b1;
        end
      end
      PhYear: begin
        if (!v[VALUE_BITS-1]) begin
          if (v < VYearWin) r.val = v + VC2000;
          else if (v < VYear100) r.val = v + VC1900;
        end
        // An empty year with a sign or non-space blank gives StNoHourColon.
        if (!n.dseen && (nds != c.ch) && (n.sign || !n.sponly)) begin
          r.stop = 1'b1; r.code = StNoHourColon;
        end else if (c.is_zero) begin
          r.stop = 1'b1;
        end else begin
          r.next = PhHskip; r.again = 1'b1;
        end
      end
      PhHour: begin
        if (nds != ChColon) begin
          r.stop = 1'b1; r.code = StNoHourColon;
        end else if (v > VHourMax) begin
          r.stop = 1'b1; r.code = StBadHour;
        end else begin
          r.next = PhMin; r.clear = 1'b1;
        end
      end
      PhMin: begin
        if (v > VMsMax) begin
          r.stop = 1'b1; r.code = StBadMinute;
        end else if (nds != ChColon) begin
          r.stop = 1'b1;
        end else begin
          r.next = PhSec; r.clear = 1'b1;
        end
      end
      PhSec: begin
        r.stop = 1'b1;
        r.code = (v > VMsMax) ? StBadSecond : StOk;
      end
      default: begin
        r.wr = 1'b0;
      end
    endcase
    return r;
  endfunction

  function automatic logic [FieldW-1:0] field_of(phase_e ph);
    unique case (ph)
      PhDay:   return FDay;
      PhMonth: return FMon;
      PhYear:  return FYear;
      PhHour:  return FHour;
      PhMin:   return FMin;
      default: return FSec;
    endcase
  endfunction

  phase_e      phase_q, phase_d;
  num_t        num_q, num_d;
  logic        fin_q, fin_d;
  dtp_status_e code_q, code_d;
  val_t        fields_q [NumFields];
  val_t        fields_d [NumFields];

  logic        out_valid_q, out_valid_d;
  val_t        out_fields_q [NumFields];
  dtp_status_e out_code_q;

  logic        out_free;
  logic        pop;
  logic        go;
  feed_t       fr1, fr2;
  close_t      cl1, cl2;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop      = q_valid_i && (!q_data_i.is_zero || out_free);
  assign q_pop_o  = pop;

  always_comb begin
    phase_d  = phase_q;
    num_d    = num_q;
    fin_d    = fin_q;
    code_d   = code_q;
    fields_d = fields_q;
    go       = 1'b0;
    fr1      = '0;
    fr2      = '0;
    cl1      = '0;
    cl2      = '0;

    // Space skipping ahead of the day or the hour; a terminator before the hour ends the parse.
    if (!fin_q) begin
      if ((phase_q == PhLead) || (phase_q == PhHskip)) begin
        if (q_data_i.is_space) begin
          go = 1'b0;
        end else if ((phase_q == PhHskip) && q_data_i.is_zero) begin
          fin_d  = 1'b1;
          code_d = StOk;
        end else begin
          phase_d = (phase_q == PhLead) ? PhDay : PhHour;
          num_d   = NumClear;
          go      = 1'b1;
        end
      end else begin
        go = 1'b1;
      end
    end

    if (go) begin
      fr1   = feed(num_d, q_data_i);
      num_d = fr1.num;
      if (fr1.last) begin
        cl1 = close_field(phase_d, num_d, q_data_i);
        if (cl1.wr) fields_d[field_of(phase_d)] = cl1.val;
        if (cl1.stop) begin
          fin_d  = 1'b1;
          code_d = cl1.code;
        end
        if (cl1.clear) num_d = NumClear;
        phase_d = cl1.next;
      end
    end

    // A year that ended at this byte passes it on to the hour scan.
    if (cl1.again && !q_data_i.is_space) begin
      phase_d = PhHour;
      fr2     = feed(NumClear, q_data_i);
      num_d   = fr2.num;
      if (fr2.last) begin
        cl2 = close_field(PhHour, num_d, q_data_i);
        fields_d[FHour] = cl2.val;
        if (cl2.stop) begin
          fin_d  = 1'b1;
          code_d = cl2.code;
        end
        if (cl2.clear) num_d = NumClear;
        phase_d = cl2.next;
      end
    end

    out_valid_d = out_valid_q && out_stall_i;
    if (pop && q_data_i.is_zero) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhLead;
      num_q       <= NumClear;
      fin_q       <= 1'b0;
      code_q      <= StOk;
      fields_q    <= '{default: '0};
      out_valid_q <= 1'b0;
      out_fields_q <= '{default: '0};
      out_code_q  <= StOk;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop) begin
        if (q_data_i.is_zero) begin
          // Terminator: publish the result and rearm for a new text.
          out_fields_q <= fields_d;
          out_code_q   <= code_d;
          phase_q      <= PhLead;
          num_q        <= NumClear;
          fin_q        <= 1'b0;
          code_q       <= StOk;
          fields_q     <= '{default: '0};
        end else begin
          phase_q  <= phase_d;
          num_q    <= num_d;
          fin_q    <= fin_d;
          code_q   <= code_d;
          fields_q <= fields_d;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign day_o       = out_fields_q[FDay];
  assign month_o     = out_fields_q[FMon];
  assign year_o      = out_fields_q[FYear];
  assign hour_o      = out_fields_q[FHour];
  assign minute_o    = out_fields_q[FMin];
  assign second_o    = out_fields_q[FSec];
  assign status_o    = out_code_q;

endmodule

FILE: rtl/core/date_time_text_parser.sv
// ----------------------------------------------------------------------------
// Date/time text parser
// Parses a 'dd/mm/[yy]yy hh:mm[:ss]' text, one byte per transfer, and gives
// one result of six fields and a status for each zero-terminated text.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake                 Payload
//   -------   ---------   -----------------------   ------------------------
//   input     in          in_valid_i / in_stall_o   ch_i
//   result    out         out_valid_o / out_stall_i day_o .. second_o, status_o
//
// The block takes one byte per cycle while the queue has room: the front end
// writes each byte into a two-entry queue, from which the parse engine takes it.
// A result enters the output register when the engine pops its terminator.
// Reset (rst_ni low) clears the queue, the scanner and the result register.
// The engine waits only when a terminator meets an untaken result; the queue
// absorbs the bytes that follow until it fills, and then in_stall_o rises.
//
module date_time_text_parser
  import dtp_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   ch_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [VALUE_BITS-1:0] day_o,
  output logic signed [VALUE_BITS-1:0] month_o,
  output logic signed [VALUE_BITS-1:0] year_o,
  output logic signed [VALUE_BITS-1:0] hour_o,
  output logic signed [VALUE_BITS-1:0] minute_o,
  output logic signed [VALUE_BITS-1:0] second_o,
  output logic [3:0]                   status_o
);

  // Classified characters on their way into the queue.
  dtp_push_t push;
  logic      q_full;

  // Queue read side toward the engine.
  logic      q_valid;
  dtp_char_t q_data;
  logic      q_pop;

  // The front end classifies each byte and stalls only on a full queue.
  dtp_front u_front (
    .in_valid_i (in_valid_i),
    .ch_i       (ch_i),
    .in_stall_o (in_stall_o),
    .full_i     (q_full),
    .push_o     (push)
  );

  // The queue decouples byte intake from result delivery.
  dtp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_data),
    .pop_i   (q_pop)
  );

  // The engine runs the field scanner and owns the result register.
  dtp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .day_o       (day_o),
    .month_o     (month_o),
    .year_o      (year_o),
    .hour_o      (hour_o),
    .minute_o    (minute_o),
    .second_o    (second_o),
    .status_o    (status_o)
  );

endmodule
